### rtl/sat_pkg.sv
// shared types and constants for the section address translator
`default_nettype none

package sat_pkg;

  localparam int ADDR_W    = 32;
  localparam int SLOT_W    = 4;
  localparam int IDX_SPAN  = 1 << SLOT_W;
  localparam int ALIGN_W   = 5;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_V2F   = 2'd2,
    CMD_F2V   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECTION_ALIGN = 1'd0,
    REG_FILE_ALIGN    = 1'd1
  } cfg_reg_t;

  // one command travelling down the row of cells
  typedef struct packed {
    logic              vld;
    cmd_t              cmd;
    logic [SLOT_W-1:0] idx;
    logic [ADDR_W-1:0] rva;
    logic [ADDR_W-1:0] vsize;
    logic [ADDR_W-1:0] ptr;
    logic [ADDR_W-1:0] fsize;
    logic [ADDR_W-1:0] query;
    logic [ADDR_W-1:0] result;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } tok_t;

endpackage

`default_nettype wire

### rtl/section_address_translator.sv
// top level: section table as a row of cells with input capture and output staging
// an accepted input transaction is registered at the head, in each cell of the row and in the
//   output register before out_tvalid; one command is in the row at a time, so a new one is
//   taken only once the last result reaches the output, and a result held back in the pending
//   slot keeps in_tready low until it reaches the output
// reset (rst_n, synchronous, active low): all entries invalid, alignments 12 and 9,
//   no transaction in flight, output empty
`default_nettype none

module section_address_translator
  import sat_pkg::*;
#(
  parameter int SECTION_SLOTS = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // input channel
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [135:0]         in_tdata,   // entry_index, section_rva, raw_size,
                                           // raw_pointer, query_address, zero pad
  input  wire  [1:0]           in_tuser,   // cmd
  // result channel
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [39:0]          out_tdata,  // translated_address, hit_slot, zero pad
  output logic                 out_tuser,  // hit
  // configuration channel
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [ALIGN_W-1:0]   cfg_data
);

  // alignment registers
  logic [ALIGN_W-1:0] sec_log2_r;
  logic [ALIGN_W-1:0] file_log2_r;

  // capture of the accepted transaction, head of the row
  tok_t               tok_in_r;
  tok_t               tok_in_nxt;
  logic               in_acc;
  logic [ADDR_W-1:0]  raw_size;
  logic [ADDR_W-1:0]  vmask;
  logic [ADDR_W-1:0]  fmask;

  // tokens between cells, tok[0] is the head register
  tok_t               tok [SECTION_SLOTS+1];

  // control and output staging
  logic               busy_r;
  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic               out_hit_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic               pend_valid_r;
  logic [ADDR_W-1:0]  pend_addr_r;
  logic               pend_hit_r;
  logic [SLOT_W-1:0]  pend_slot_r;
  logic               out_free;
  tok_t               tail;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;

  // configuration writes, out of list indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_log2_r  <= ALIGN_W'(12);
      file_log2_r <= ALIGN_W'(9);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SECTION_ALIGN: sec_log2_r  <= cfg_data;
        REG_FILE_ALIGN:    file_log2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // round the raw size up to each alignment here so the cells only add
  assign raw_size = in_tdata[67:36];
  assign vmask    = (ADDR_W'(1) << sec_log2_r) - ADDR_W'(1);
  assign fmask    = (ADDR_W'(1) << file_log2_r) - ADDR_W'(1);

  always_comb begin
    tok_in_nxt.vld    = in_acc;
    tok_in_nxt.cmd    = cmd_t'(in_tuser);
    tok_in_nxt.idx    = in_tdata[3:0];
    tok_in_nxt.rva    = in_tdata[35:4];
    tok_in_nxt.vsize  = (raw_size + vmask) & ~vmask;
    tok_in_nxt.ptr    = in_tdata[99:68];
    tok_in_nxt.fsize  = (raw_size + fmask) & ~fmask;
    tok_in_nxt.query  = in_tdata[131:100];
    // load and clear leave these at zero, a miss too
    tok_in_nxt.result = '0;
    tok_in_nxt.hit    = 1'b0;
    tok_in_nxt.slot   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_in_r.vld <= 1'b0;
    end else begin
      tok_in_r <= tok_in_nxt;
    end
  end

  assign tok[0] = tok_in_r;

  // row of cells, cell i holds table slot i
  for (genvar gi = 0; gi < SECTION_SLOTS; gi++) begin : g_cell
    sat_cell #(
      .CELL_ID (gi)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok[gi]),
      .tok_o (tok[gi+1])
    );
  end

  assign tail     = tok[SECTION_SLOTS];
  assign out_free = !out_valid_r || out_tready;

  // output register plus one pending slot for a result that finds the output full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      busy_r       <= 1'b0;
    end else begin
      if (out_free) begin
        if (pend_valid_r) begin
          out_valid_r  <= 1'b1;
          pend_valid_r <= 1'b0;
          busy_r       <= 1'b0;
        end else if (tail.vld) begin
          out_valid_r <= 1'b1;
          busy_r      <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (tail.vld) begin
        pend_valid_r <= 1'b1;
      end
      if (in_acc) begin
        busy_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid_r) begin
        out_addr_r <= pend_addr_r;
        out_hit_r  <= pend_hit_r;
        out_slot_r <= pend_slot_r;
      end else if (tail.vld) begin
        out_addr_r <= tail.result;
        out_hit_r  <= tail.hit;
        out_slot_r <= tail.slot;
      end
    end else if (tail.vld) begin
      pend_addr_r <= tail.result;
      pend_hit_r  <= tail.hit;
      pend_slot_r <= tail.slot;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_slot_r, out_addr_r};
  assign out_tuser  = out_hit_r;

`ifndef SYNTHESIS
  // one command at a time: nothing is taken in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a command is in flight");

  // a miss always reports a zero address and slot
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata[35:0] == 36'd0))
    else $error("miss with non-zero address or slot");

  // a pending result only exists behind a full output register
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r && busy_r)
    else $error("pending result without a held output");

  // a result leaving the row never meets a held pending one
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> !pend_valid_r && busy_r)
    else $error("result overran the pending slot");
`endif

endmodule

`default_nettype wire

### rtl/sat_cell.sv
// one section table entry with its load, clear and range match logic
`default_nettype none

module sat_cell
  import sat_pkg::*;
#(
  parameter int CELL_ID = 0
) (
  input  wire  clk,
  input  wire  rst_n,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic              valid_r;
  logic              valid_nxt;
  logic [ADDR_W-1:0] vb_r;
  logic [ADDR_W-1:0] ve_r;
  logic [ADDR_W-1:0] fb_r;
  logic [ADDR_W-1:0] fe_r;
  tok_t              tok_r;
  tok_t              tok_nxt;

  logic              is_mine;
  logic              is_query;
  logic              to_file;
  logic [ADDR_W-1:0] b;
  logic [ADDR_W-1:0] e;
  logic [ADDR_W-1:0] ob;
  logic              in_range;

  // a load addressed past the table matches no cell
  assign is_mine = tok_i.vld && (tok_i.cmd == CMD_LOAD) && (CELL_ID < IDX_SPAN)
                   && (tok_i.idx == SLOT_W'(CELL_ID));
  assign is_query = tok_i.vld && ((tok_i.cmd == CMD_V2F) || (tok_i.cmd == CMD_F2V));
  assign to_file  = (tok_i.cmd == CMD_V2F);
  assign b        = to_file ? vb_r : fb_r;
  assign e        = to_file ? ve_r : fe_r;
  assign ob       = to_file ? fb_r : vb_r;
  assign in_range = (tok_i.query >= b) && (tok_i.query < e);

  always_comb begin
    valid_nxt = valid_r;
    if (tok_i.vld && (tok_i.cmd == CMD_CLEAR)) begin
      valid_nxt = 1'b0;
    end else if (is_mine) begin
      valid_nxt = 1'b1;
    end
  end

  // lower cells have already had their chance, so first hit wins
  always_comb begin
    tok_nxt = tok_i;
    if (is_query && !tok_i.hit && valid_r && in_range) begin
      tok_nxt.hit    = 1'b1;
      tok_nxt.result = tok_i.query - b + ob;
      tok_nxt.slot   = SLOT_W'(CELL_ID);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_mine) begin
      vb_r <= tok_i.rva;
      ve_r <= tok_i.rva + tok_i.vsize;
      fb_r <= tok_i.ptr;
      fe_r <= tok_i.ptr + tok_i.fsize;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire
